@@ src/prc_pkg.sv @@
package prc_pkg;

   // request opcodes (req_tuser)
   localparam logic [2:0] OP_TICK        = 3'd0;
   localparam logic [2:0] OP_OPEN        = 3'd1;
   localparam logic [2:0] OP_CLOSE       = 3'd2;
   localparam logic [2:0] OP_OPEN_CAND   = 3'd3;
   localparam logic [2:0] OP_JOIN        = 3'd4;
   localparam logic [2:0] OP_CONFIRM     = 3'd5;

   // reply kinds (rsp_tuser)
   localparam logic [2:0] KIND_NONE      = 3'd0;
   localparam logic [2:0] KIND_OFFER     = 3'd1;
   localparam logic [2:0] KIND_ACK       = 3'd2;
   localparam logic [2:0] KIND_CAND_OK   = 3'd3;
   localparam logic [2:0] KIND_CAND_REF  = 3'd4;

   // config register indexes
   localparam logic [1:0] CSR_WINDOW_LEN = 2'd0;
   localparam logic [1:0] CSR_CAND_LEN   = 2'd1;
   localparam logic [1:0] CSR_CAND_COOL  = 2'd2;

   localparam int CSR_W       = 31;
   localparam int MAC_W       = 48;
   localparam int UID_W       = 48;
   localparam int TIME_W      = 32;
   localparam int SESS_W      = 32;
   localparam int NODE_W      = 16;
   localparam int TOTAL_W     = 4;
   localparam int REQ_DATA_W  = 176;
   localparam int RSP_DATA_W  = 152;

   localparam logic [CSR_W-1:0]  WINDOW_LEN_RST = 31'd60000;
   localparam logic [CSR_W-1:0]  CAND_LEN_RST   = 31'd30000;
   localparam logic [CSR_W-1:0]  CAND_COOL_RST  = 31'd0;
   localparam logic [NODE_W-1:0] NEXT_ID_RST    = 16'd1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_TAIL   = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

endpackage

@@ src/pairing_registry_coordinator.sv @@
// Pairing registry coordinator.
// Input channel req_*: one item per message or command; req_tuser is the opcode
// (tick, open, close, open candidate, join, confirm), req_tdata the payload.
// Output channel rsp_*: exactly one result item per input item, in order.
// Config port csr_*: write-only registers, to be written by the user only
// while the block idles; the block itself does not enforce this. One item
// at a time: join and confirm sweep the slot registry one slot per cycle
// through the shared compare unit, then pass the tail and decide states
// before the result is registered; other ops go straight to decide. After
// the result is taken the block returns to idle before it takes the next item.
// req_tready is high only while idle. If the receiver stalls, the result
// holds in the output register and no new item is taken until it drains.
// Reset (synchronous) empties the registry (used bits cleared), closes the
// window, clears pending session and candidate filter, sets next id to 1 and
// restores register defaults. Slot contents live in a small memory that is
// only read behind its used bit, so it needs no clearing pass.
module pairing_registry_coordinator #(
   parameter int REGISTRY_SLOTS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // op
   input  logic [2:0]                        req_tuser,
   // now_ms, src_mac, device_uid, session_id, node_id
   input  logic [prc_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // reply_kind
   output logic [2:0]                        rsp_tuser,
   // dest_mac, reply_uid, reply_session, reply_node_id, registry_changed,
   // window_is_open, paired_total, 2 zero pad bits
   output logic [prc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [prc_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int IDX_W = (REGISTRY_SLOTS > 1) ? $clog2(REGISTRY_SLOTS) : 1;
   localparam int CNT_W = $clog2(REGISTRY_SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(REGISTRY_SLOTS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(REGISTRY_SLOTS);

   // config registers
   logic [prc_pkg::CSR_W-1:0] win_len_ff, cand_len_ff, cand_cool_ff;

   // protocol state
   prc_pkg::state_type state_ff, state_in;
   logic [REGISTRY_SLOTS-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]           used_count_ff, used_count_in;
   logic [prc_pkg::NODE_W-1:0] next_id_ff, next_id_in;
   logic [prc_pkg::NODE_W-1:0] pend_id_ff, pend_id_in;
   logic [prc_pkg::SESS_W-1:0] pend_sess_ff, pend_sess_in;
   logic [prc_pkg::UID_W-1:0]  pend_uid_ff, pend_uid_in;
   logic                       win_open_ff, win_open_in;
   logic [prc_pkg::TIME_W-1:0] deadline_ff, deadline_in;
   logic                       filt_ff, filt_in;
   logic [prc_pkg::MAC_W-1:0]  cand_mac_ff, cand_mac_in;
   logic [prc_pkg::TIME_W-1:0] last_cand_ff, last_cand_in;

   // captured item
   logic [2:0]                 in_op_ff, in_op_in;
   logic [prc_pkg::TIME_W-1:0] in_now_ff, in_now_in;
   logic [prc_pkg::MAC_W-1:0]  in_mac_ff, in_mac_in;
   logic [prc_pkg::UID_W-1:0]  in_uid_ff, in_uid_in;
   logic [prc_pkg::SESS_W-1:0] in_sess_ff, in_sess_in;
   logic [prc_pkg::NODE_W-1:0] in_nid_ff, in_nid_in;

   // slot memory
   logic [prc_pkg::NODE_W-1:0] slot_node_ff [REGISTRY_SLOTS];
   logic [prc_pkg::MAC_W-1:0]  slot_mac_ff  [REGISTRY_SLOTS];
   logic [prc_pkg::UID_W-1:0]  slot_uid_ff  [REGISTRY_SLOTS];
   logic                       slot_we;
   logic [IDX_W-1:0]           slot_wa;

   // sweep: address counter and registered read data
   logic [IDX_W-1:0]           cnt_ff, cnt_in;
   logic [IDX_W-1:0]           rd_idx_ff;
   logic                       rd_go_ff;
   logic [prc_pkg::NODE_W-1:0] rd_node_ff;
   logic [prc_pkg::MAC_W-1:0]  rd_mac_ff;
   logic [prc_pkg::UID_W-1:0]  rd_uid_ff;

   // first-hit trackers
   logic                       mac_hit_ff, mac_hit_in, mac_eq_ff, mac_eq_in;
   logic [IDX_W-1:0]           mac_idx_ff, mac_idx_in;
   logic [prc_pkg::NODE_W-1:0] mac_node_ff, mac_node_in;
   logic                       uid_hit_ff, uid_hit_in, uid_eq_ff, uid_eq_in;
   logic [IDX_W-1:0]           uid_idx_ff, uid_idx_in;
   logic [prc_pkg::NODE_W-1:0] uid_node_ff, uid_node_in;
   logic                       idm_hit_ff, idm_hit_in, idm_eq_ff, idm_eq_in;
   logic [IDX_W-1:0]           idm_idx_ff, idm_idx_in;
   logic                       free_hit_ff, free_hit_in;
   logic [IDX_W-1:0]           free_idx_ff, free_idx_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [2:0]                 rsp_kind_ff, rsp_kind_in;
   logic [prc_pkg::MAC_W-1:0]  rsp_mac_ff, rsp_mac_in;
   logic [prc_pkg::UID_W-1:0]  rsp_uid_ff, rsp_uid_in;
   logic [prc_pkg::SESS_W-1:0] rsp_sess_ff, rsp_sess_in;
   logic [prc_pkg::NODE_W-1:0] rsp_node_ff, rsp_node_in;
   logic                       rsp_chg_ff, rsp_chg_in;
   logic                       rsp_win_ff, rsp_win_in;
   logic [CNT_W-1:0]           rsp_cnt_ff, rsp_cnt_in;

   // shared compare unit on the slot being read
   logic rd_used, cmp_mac, cmp_uid, cmp_node;
   assign rd_used  = used_ff[rd_idx_ff];
   assign cmp_mac  = rd_mac_ff == in_mac_ff;
   assign cmp_uid  = rd_uid_ff == in_uid_ff;
   assign cmp_node = rd_node_ff == in_nid_ff;

   // time arithmetic for the decide step
   logic [prc_pkg::TIME_W-1:0] since_deadline, since_cand;
   assign since_deadline = in_now_ff - deadline_ff;
   assign since_cand     = in_now_ff - last_cand_ff;

   always_comb begin
      logic cand_refuse;
      logic admit;
      logic pick_hit, pick_eq, pick_new;
      logic [IDX_W-1:0] pick_idx;

      state_in      = state_ff;
      used_in       = used_ff;
      used_count_in = used_count_ff;
      next_id_in    = next_id_ff;
      pend_id_in    = pend_id_ff;
      pend_sess_in  = pend_sess_ff;
      pend_uid_in   = pend_uid_ff;
      win_open_in   = win_open_ff;
      deadline_in   = deadline_ff;
      filt_in       = filt_ff;
      cand_mac_in   = cand_mac_ff;
      last_cand_in  = last_cand_ff;
      in_op_in      = in_op_ff;
      in_now_in     = in_now_ff;
      in_mac_in     = in_mac_ff;
      in_uid_in     = in_uid_ff;
      in_sess_in    = in_sess_ff;
      in_nid_in     = in_nid_ff;
      cnt_in        = cnt_ff;
      mac_hit_in    = mac_hit_ff;
      mac_eq_in     = mac_eq_ff;
      mac_idx_in    = mac_idx_ff;
      mac_node_in   = mac_node_ff;
      uid_hit_in    = uid_hit_ff;
      uid_eq_in     = uid_eq_ff;
      uid_idx_in    = uid_idx_ff;
      uid_node_in   = uid_node_ff;
      idm_hit_in    = idm_hit_ff;
      idm_eq_in     = idm_eq_ff;
      idm_idx_in    = idm_idx_ff;
      free_hit_in   = free_hit_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_mac_in    = rsp_mac_ff;
      rsp_uid_in    = rsp_uid_ff;
      rsp_sess_in   = rsp_sess_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_chg_in    = rsp_chg_ff;
      rsp_win_in    = rsp_win_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      slot_we       = 1'b0;
      slot_wa       = free_idx_ff;
      cand_refuse   = 1'b0;
      admit         = 1'b0;
      pick_hit      = 1'b0;
      pick_eq       = 1'b0;
      pick_new      = 1'b0;
      pick_idx      = free_idx_ff;

      // first-hit search, one slot per cycle, on the registered read data of the swept address
      if (rd_go_ff) begin
         if (!idm_hit_ff && rd_used && cmp_mac && cmp_node) begin
            idm_hit_in = 1'b1;
            idm_idx_in = rd_idx_ff;
            idm_eq_in  = cmp_uid;
         end
         if (!mac_hit_ff && rd_used && cmp_mac) begin
            mac_hit_in  = 1'b1;
            mac_idx_in  = rd_idx_ff;
            mac_node_in = rd_node_ff;
            mac_eq_in   = cmp_node && cmp_uid;
         end
         if (!uid_hit_ff && rd_used && cmp_uid) begin
            uid_hit_in  = 1'b1;
            uid_idx_in  = rd_idx_ff;
            uid_node_in = rd_node_ff;
            uid_eq_in   = cmp_node && cmp_mac;
         end
         if (!free_hit_ff && !rd_used) begin
            free_hit_in = 1'b1;
            free_idx_in = rd_idx_ff;
         end
      end

      unique case (state_ff)
         prc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               in_op_in    = req_tuser;
               in_now_in   = req_tdata[31:0];
               in_mac_in   = req_tdata[79:32];
               in_uid_in   = req_tdata[127:80];
               in_sess_in  = req_tdata[159:128];
               in_nid_in   = req_tdata[175:160];
               cnt_in      = '0;
               mac_hit_in  = 1'b0;
               uid_hit_in  = 1'b0;
               idm_hit_in  = 1'b0;
               free_hit_in = 1'b0;
               if (req_tuser == prc_pkg::OP_JOIN || req_tuser == prc_pkg::OP_CONFIRM) begin
                  state_in = prc_pkg::ST_SCAN;
               end else begin
                  state_in = prc_pkg::ST_DECIDE;
               end
            end
         end
         prc_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_ff == LAST_IDX) begin
               state_in = prc_pkg::ST_TAIL;
            end
         end
         prc_pkg::ST_TAIL: begin
            state_in = prc_pkg::ST_DECIDE;
         end
         prc_pkg::ST_DECIDE: begin
            rsp_kind_in = prc_pkg::KIND_NONE;
            rsp_mac_in  = '0;
            rsp_uid_in  = '0;
            rsp_sess_in = '0;
            rsp_node_in = '0;
            rsp_chg_in  = 1'b0;
            unique case (in_op_ff)
               prc_pkg::OP_TICK: begin
                  if (win_open_ff && !since_deadline[31]) begin
                     win_open_in = 1'b0;
                     deadline_in = '0;
                     filt_in     = 1'b0;
                     cand_mac_in = '0;
                  end
               end
               prc_pkg::OP_OPEN: begin
                  win_open_in = 1'b1;
                  deadline_in = in_now_ff + {1'b0, win_len_ff};
                  filt_in     = 1'b0;
                  cand_mac_in = '0;
               end
               prc_pkg::OP_CLOSE: begin
                  win_open_in = 1'b0;
                  deadline_in = '0;
                  filt_in     = 1'b0;
                  cand_mac_in = '0;
               end
               prc_pkg::OP_OPEN_CAND: begin
                  cand_refuse = (cand_len_ff == '0) ||
                                ((cand_cool_ff != '0) && (last_cand_ff != '0) &&
                                 (since_cand[31] || (since_cand < {1'b0, cand_cool_ff})));
                  if (cand_refuse) begin
                     rsp_kind_in = prc_pkg::KIND_CAND_REF;
                  end else begin
                     win_open_in  = 1'b1;
                     deadline_in  = in_now_ff + {1'b0, cand_len_ff};
                     filt_in      = 1'b1;
                     cand_mac_in  = in_mac_ff;
                     last_cand_in = in_now_ff;
                     rsp_kind_in  = prc_pkg::KIND_CAND_OK;
                  end
               end
               prc_pkg::OP_JOIN: begin
                  admit = win_open_ff && !(filt_ff && (in_mac_ff != cand_mac_ff));
                  if (admit && (mac_hit_ff || uid_hit_ff || used_count_ff < FULL_CNT)) begin
                     if (mac_hit_ff) begin
                        rsp_node_in = mac_node_ff;
                     end else if (uid_hit_ff) begin
                        rsp_node_in = uid_node_ff;
                     end else begin
                        rsp_node_in = next_id_ff;
                        next_id_in  = next_id_ff + prc_pkg::NODE_W'(1);
                     end
                     pend_id_in   = rsp_node_in;
                     pend_sess_in = in_sess_ff;
                     pend_uid_in  = in_uid_ff;
                     rsp_kind_in  = prc_pkg::KIND_OFFER;
                     rsp_mac_in   = in_mac_ff;
                     rsp_uid_in   = in_uid_ff;
                     rsp_sess_in  = in_sess_ff;
                  end
               end
               prc_pkg::OP_CONFIRM: begin
                  if (in_sess_ff == pend_sess_ff && in_nid_ff == pend_id_ff &&
                      in_uid_ff == pend_uid_ff) begin
                     // upsert priority: id+mac, mac, uid, first free slot
                     if (idm_hit_ff) begin
                        pick_hit = 1'b1;
                        pick_idx = idm_idx_ff;
                        pick_eq  = idm_eq_ff;
                     end else if (mac_hit_ff) begin
                        pick_hit = 1'b1;
                        pick_idx = mac_idx_ff;
                        pick_eq  = mac_eq_ff;
                     end else if (uid_hit_ff) begin
                        pick_hit = 1'b1;
                        pick_idx = uid_idx_ff;
                        pick_eq  = uid_eq_ff;
                     end else if (free_hit_ff) begin
                        pick_hit = 1'b1;
                        pick_idx = free_idx_ff;
                        pick_new = 1'b1;
                     end
                     if (pick_hit && !pick_eq) begin
                        slot_we           = 1'b1;
                        slot_wa           = pick_idx;
                        used_in[pick_idx] = 1'b1;
                        rsp_chg_in        = 1'b1;
                        if (pick_new) begin
                           used_count_in = used_count_ff + CNT_W'(1);
                        end
                     end
                     rsp_kind_in = prc_pkg::KIND_ACK;
                     rsp_mac_in  = in_mac_ff;
                     rsp_uid_in  = in_uid_ff;
                     rsp_sess_in = in_sess_ff;
                     rsp_node_in = in_nid_ff;
                  end
               end
               default: begin
                  // unknown opcode: ignored
               end
            endcase
            rsp_win_in   = win_open_in;
            rsp_cnt_in   = used_count_in;
            rsp_valid_in = 1'b1;
            state_in     = prc_pkg::ST_RESP;
         end
         prc_pkg::ST_RESP: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = prc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = prc_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= prc_pkg::ST_IDLE;
         used_ff       <= '0;
         used_count_ff <= '0;
         next_id_ff    <= prc_pkg::NEXT_ID_RST;
         pend_id_ff    <= '0;
         pend_sess_ff  <= '0;
         pend_uid_ff   <= '0;
         win_open_ff   <= 1'b0;
         deadline_ff   <= '0;
         filt_ff       <= 1'b0;
         cand_mac_ff   <= '0;
         last_cand_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_go_ff      <= 1'b0;
         win_len_ff    <= prc_pkg::WINDOW_LEN_RST;
         cand_len_ff   <= prc_pkg::CAND_LEN_RST;
         cand_cool_ff  <= prc_pkg::CAND_COOL_RST;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         used_count_ff <= used_count_in;
         next_id_ff    <= next_id_in;
         pend_id_ff    <= pend_id_in;
         pend_sess_ff  <= pend_sess_in;
         pend_uid_ff   <= pend_uid_in;
         win_open_ff   <= win_open_in;
         deadline_ff   <= deadline_in;
         filt_ff       <= filt_in;
         cand_mac_ff   <= cand_mac_in;
         last_cand_ff  <= last_cand_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_go_ff      <= (state_ff == prc_pkg::ST_SCAN);
         if (csr_we) begin
            unique case (csr_index)
               prc_pkg::CSR_WINDOW_LEN: win_len_ff   <= csr_wdata;
               prc_pkg::CSR_CAND_LEN:   cand_len_ff  <= csr_wdata;
               prc_pkg::CSR_CAND_COOL:  cand_cool_ff <= csr_wdata;
               default: begin
                  // no register at this index
               end
            endcase
         end
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      in_op_ff    <= in_op_in;
      in_now_ff   <= in_now_in;
      in_mac_ff   <= in_mac_in;
      in_uid_ff   <= in_uid_in;
      in_sess_ff  <= in_sess_in;
      in_nid_ff   <= in_nid_in;
      cnt_ff      <= cnt_in;
      mac_hit_ff  <= mac_hit_in;
      mac_eq_ff   <= mac_eq_in;
      mac_idx_ff  <= mac_idx_in;
      mac_node_ff <= mac_node_in;
      uid_hit_ff  <= uid_hit_in;
      uid_eq_ff   <= uid_eq_in;
      uid_idx_ff  <= uid_idx_in;
      uid_node_ff <= uid_node_in;
      idm_hit_ff  <= idm_hit_in;
      idm_eq_ff   <= idm_eq_in;
      idm_idx_ff  <= idm_idx_in;
      free_hit_ff <= free_hit_in;
      free_idx_ff <= free_idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_mac_ff  <= rsp_mac_in;
      rsp_uid_ff  <= rsp_uid_in;
      rsp_sess_ff <= rsp_sess_in;
      rsp_node_ff <= rsp_node_in;
      rsp_chg_ff  <= rsp_chg_in;
      rsp_win_ff  <= rsp_win_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   // slot memory: one write port, one registered read port at the sweep address
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_node_ff[slot_wa] <= in_nid_ff;
         slot_mac_ff[slot_wa]  <= in_mac_ff;
         slot_uid_ff[slot_wa]  <= in_uid_ff;
      end
      rd_node_ff <= slot_node_ff[cnt_ff];
      rd_mac_ff  <= slot_mac_ff[cnt_ff];
      rd_uid_ff  <= slot_uid_ff[cnt_ff];
      rd_idx_ff  <= cnt_ff;
   end

   assign req_tready = (state_ff == prc_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {2'b00, prc_pkg::TOTAL_W'(rsp_cnt_ff), rsp_win_ff, rsp_chg_ff,
                        rsp_node_ff, rsp_sess_ff, rsp_uid_ff, rsp_mac_ff};

   // registry bookkeeping stays consistent
   a_count_matches_used: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(used_count_ff))
      else $error("used count out of step with used bits");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= FULL_CNT)
      else $error("used count above slot count");

   // one item at a time: never ready while a result is pending
   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_tready)
      else $error("ready while result outstanding");

   a_decide_gives_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == prc_pkg::ST_DECIDE) |=> rsp_valid_ff)
      else $error("decide step produced no result");

   a_payload_only_on_reply: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff != prc_pkg::KIND_OFFER &&
       rsp_kind_ff != prc_pkg::KIND_ACK) |->
      (rsp_mac_ff == '0 && rsp_uid_ff == '0 && rsp_sess_ff == '0 && rsp_node_ff == '0))
      else $error("payload set on a non-reply result");

endmodule
